>>> src/pqd_pkg.sv
`default_nettype none
package pqd_pkg;

  // Field layout of the packed word
  localparam int WORD_W      = 40;
  localparam int FIELD_W     = 12;
  localparam int NUM_FIELDS  = 3;
  localparam int SLOT_LSB    = 36;
  localparam int NEGATE_BIT  = 38;
  localparam logic [FIELD_W-1:0] FIELD_OFFSET = 12'd2049;

  // Scale 0.000345436 in Q32, rounded
  localparam int SCALE_W = 21;
  localparam logic [SCALE_W-1:0] SCALE_Q32 = 21'd1483636;

  // Internal fixed point: magnitudes in Q30, squares in Q60
  localparam int INT_FRAC_BITS = 30;
  localparam int MAG_W         = INT_FRAC_BITS;
  localparam int PROD_W        = FIELD_W + SCALE_W;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int RAD_W         = 2 * INT_FRAC_BITS + 1;
  localparam int ROOT_W        = INT_FRAC_BITS + 1;

  // Output format
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_W         = 16;
  localparam int OUT_SHIFT     = INT_FRAC_BITS - OUT_FRAC_BITS;
  localparam int RND_W         = ROOT_W + 2;

  // Slot indexes of the four outputs
  localparam logic [1:0] SLOT_X = 2'd0;
  localparam logic [1:0] SLOT_Y = 2'd1;
  localparam logic [1:0] SLOT_Z = 2'd2;
  localparam logic [1:0] SLOT_W = 2'd3;

  // Data carried alongside the radicand through the root pipeline
  typedef struct packed {
    logic [1:0]                       slot;
    logic                             negate;
    logic [NUM_FIELDS-1:0][OUT_W-1:0] dec;
  } side_t;

  // Q30 magnitude and sign to a saturated two's complement output value,
  // rounding half away from zero
  function automatic logic [OUT_W-1:0] to_out(input logic [ROOT_W-1:0] mag,
                                              input logic neg);
    logic [RND_W-1:0] rnd;
    logic [RND_W-1:0] q;
    logic [OUT_W-1:0] sat;
    rnd = {1'b0, mag, 1'b0} + (RND_W'(1) << OUT_SHIFT);
    q   = rnd >> (OUT_SHIFT + 1);
    if (!neg && q > RND_W'(32767)) begin
      sat = 16'h7FFF;
    end else if (neg && q > RND_W'(32768)) begin
      sat = 16'h8000;
    end else begin
      sat = q[OUT_W-1:0];
    end
    return neg ? (~sat + 16'd1) : sat;
  endfunction

endpackage
`default_nettype wire

>>> src/packed_quaternion_40bit_decode.sv
`default_nettype none
// Smallest-three quaternion decode of a 40-bit word. Bits 0-35 hold three
// 12-bit offset-binary components, bits 36-37 the slot of the rebuilt
// component and bit 38 its negate flag; bit 39 is ignored. Outputs are signed
// Q2.14. The block takes one word every cycle while in_stall_o is low and
// keeps no state between words. From an accepted word to its result on the
// output there are five stages of recentre, scale, square and sum, 31 stages
// of the bit-per-stage square root (one stage for each root bit), one stage of
// rounding and slot placement and the output register. in_stall_o rises when
// the output has been stalled long enough to fill the two-entry output
// buffer; the whole pipeline then holds while the skid entry is full, and
// moves again in the cycle after the output takes a transaction.
module packed_quaternion_40bit_decode (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [pqd_pkg::WORD_W-1:0]   packed_word_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [pqd_pkg::OUT_W-1:0]  comp_x_o,
  output logic signed [pqd_pkg::OUT_W-1:0]  comp_y_o,
  output logic signed [pqd_pkg::OUT_W-1:0]  comp_z_o,
  output logic signed [pqd_pkg::OUT_W-1:0]  comp_w_o
);

  localparam int NF = pqd_pkg::NUM_FIELDS;
  localparam logic [pqd_pkg::RAD_W-1:0] One = pqd_pkg::RAD_W'(1) << (2 * pqd_pkg::INT_FRAC_BITS);

  logic en;

  // Stage 1: recentred magnitudes and signs
  logic                          s1_valid_q;
  logic [NF-1:0][pqd_pkg::FIELD_W-1:0] s1_abs_q;
  logic [NF-1:0]                 s1_neg_q;
  logic [1:0]                    s1_slot_q;
  logic                          s1_negate_q;
  logic [NF-1:0][pqd_pkg::FIELD_W-1:0] s1_abs_d;
  logic [NF-1:0]                 s1_neg_d;

  always_comb begin
    logic [pqd_pkg::FIELD_W-1:0] fld;
    for (int k = 0; k < NF; k++) begin
      fld = packed_word_i[pqd_pkg::FIELD_W*k +: pqd_pkg::FIELD_W];
      s1_neg_d[k] = fld < pqd_pkg::FIELD_OFFSET;
      s1_abs_d[k] = s1_neg_d[k] ? (pqd_pkg::FIELD_OFFSET - fld)
                                : (fld - pqd_pkg::FIELD_OFFSET);
    end
  end

  // Stage 2: scale into Q30 magnitudes
  logic                                s2_valid_q;
  logic [NF-1:0][pqd_pkg::MAG_W-1:0]   s2_mag_q;
  logic [NF-1:0]                       s2_neg_q;
  logic [1:0]                          s2_slot_q;
  logic                                s2_negate_q;
  logic [NF-1:0][pqd_pkg::MAG_W-1:0]   s2_mag_d;

  always_comb begin
    logic [pqd_pkg::PROD_W-1:0] prod;
    for (int k = 0; k < NF; k++) begin
      prod = {{pqd_pkg::SCALE_W{1'b0}}, s1_abs_q[k]}
           * {{pqd_pkg::FIELD_W{1'b0}}, pqd_pkg::SCALE_Q32};
      prod = prod + pqd_pkg::PROD_W'(2);
      s2_mag_d[k] = prod[pqd_pkg::MAG_W+1:2];
    end
  end

  // Stage 3: squares, and the decoded components in output format
  logic                                s3_valid_q;
  logic [NF-1:0][pqd_pkg::SQ_W-1:0]    s3_sq_q;
  logic [NF-1:0][pqd_pkg::OUT_W-1:0]   s3_dec_q;
  logic [1:0]                          s3_slot_q;
  logic                                s3_negate_q;

  // Stage 4: sum of squares
  logic                                s4_valid_q;
  logic [pqd_pkg::RAD_W-1:0]           s4_sum_q;
  pqd_pkg::side_t                      s4_side_q;

  // Stage 5: one minus the sum, clamped at zero
  logic                                s5_valid_q;
  logic [pqd_pkg::RAD_W-1:0]           s5_rem_q;
  pqd_pkg::side_t                      s5_side_q;

  // Root pipeline outputs
  logic                                rt_valid;
  logic [pqd_pkg::ROOT_W-1:0]          rt_root;
  pqd_pkg::side_t                      rt_side;

  // Placement stage
  logic                                pl_valid_q;
  logic [3:0][pqd_pkg::OUT_W-1:0]      pl_comp_q;
  logic [3:0][pqd_pkg::OUT_W-1:0]      pl_comp_d;

  // Output register and skid entry
  logic                                out_valid_q;
  logic [3:0][pqd_pkg::OUT_W-1:0]      out_comp_q;
  logic                                skid_valid_q;
  logic [3:0][pqd_pkg::OUT_W-1:0]      skid_comp_q;
  logic                                pop;
  logic                                push;

  // Advance the whole pipeline while the skid entry is free
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      pl_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      pl_valid_q <= rt_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_abs_q    <= s1_abs_d;
      s1_neg_q    <= s1_neg_d;
      s1_slot_q   <= packed_word_i[pqd_pkg::SLOT_LSB +: 2];
      s1_negate_q <= packed_word_i[pqd_pkg::NEGATE_BIT];

      s2_mag_q    <= s2_mag_d;
      s2_neg_q    <= s1_neg_q;
      s2_slot_q   <= s1_slot_q;
      s2_negate_q <= s1_negate_q;

      for (int k = 0; k < NF; k++) begin
        s3_sq_q[k]  <= {{pqd_pkg::MAG_W{1'b0}}, s2_mag_q[k]}
                     * {{pqd_pkg::MAG_W{1'b0}}, s2_mag_q[k]};
        s3_dec_q[k] <= pqd_pkg::to_out({1'b0, s2_mag_q[k]}, s2_neg_q[k]);
      end
      s3_slot_q   <= s2_slot_q;
      s3_negate_q <= s2_negate_q;

      s4_sum_q         <= {1'b0, s3_sq_q[0]} + {1'b0, s3_sq_q[1]} + {1'b0, s3_sq_q[2]};
      s4_side_q.slot   <= s3_slot_q;
      s4_side_q.negate <= s3_negate_q;
      s4_side_q.dec    <= s3_dec_q;

      s5_rem_q  <= (s4_sum_q >= One) ? '0 : (One - s4_sum_q);
      s5_side_q <= s4_side_q;

      pl_comp_q <= pl_comp_d;
    end
  end

  pqd_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s5_valid_q),
    .radicand_i (s5_rem_q),
    .side_i     (s5_side_q),
    .valid_o    (rt_valid),
    .root_o     (rt_root),
    .side_o     (rt_side)
  );

  // Place the rebuilt component at its slot, the others in order around it
  always_comb begin
    logic [pqd_pkg::OUT_W-1:0] w;
    w = pqd_pkg::to_out(rt_root, rt_side.negate);
    pl_comp_d[0] = (rt_side.slot == pqd_pkg::SLOT_X) ? w : rt_side.dec[0];
    pl_comp_d[1] = (rt_side.slot == pqd_pkg::SLOT_Y) ? w
                 : (rt_side.slot == pqd_pkg::SLOT_X) ? rt_side.dec[0] : rt_side.dec[1];
    pl_comp_d[2] = (rt_side.slot == pqd_pkg::SLOT_Z) ? w
                 : (rt_side.slot == pqd_pkg::SLOT_W) ? rt_side.dec[2] : rt_side.dec[1];
    pl_comp_d[3] = (rt_side.slot == pqd_pkg::SLOT_W) ? w : rt_side.dec[2];
  end

  // Output register with one skid entry behind it
  assign pop  = out_valid_q && !out_stall_i;
  assign push = en && pl_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || pop) begin
        out_valid_q <= skid_valid_q || push;
      end
      if (push && out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      out_comp_q <= skid_valid_q ? skid_comp_q : pl_comp_q;
    end
    if (push && out_valid_q && !pop) begin
      skid_comp_q <= pl_comp_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign comp_x_o    = out_comp_q[0];
  assign comp_y_o    = out_comp_q[1];
  assign comp_z_o    = out_comp_q[2];
  assign comp_w_o    = out_comp_q[3];

  // The skid entry fills only behind a stalled, full output register
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid entry filled without a stalled output");

  // A held skid entry implies a held output
  a_skid_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // A taken output with a skid entry behind it is refilled at once
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && skid_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry not moved into output register");

endmodule
`default_nettype wire

>>> src/pqd_isqrt.sv
`default_nettype none
// Pipelined floor square root: one result bit settled per stage
module pqd_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [pqd_pkg::RAD_W-1:0]     radicand_i,
  input  wire pqd_pkg::side_t                side_i,
  output logic                               valid_o,
  output logic [pqd_pkg::ROOT_W-1:0]         root_o,
  output pqd_pkg::side_t                     side_o
);

  localparam int NStage = pqd_pkg::ROOT_W;

  logic [pqd_pkg::RAD_W-1:0]  rem_q   [NStage];
  logic [pqd_pkg::ROOT_W-1:0] root_q  [NStage];
  logic                       valid_q [NStage];
  pqd_pkg::side_t             side_q  [NStage];

  for (genvar j = 0; j < NStage; j++) begin : g_stage
    localparam int Bit = NStage - 1 - j;

    logic [pqd_pkg::RAD_W-1:0]  rem_in;
    logic [pqd_pkg::ROOT_W-1:0] root_in;
    logic                       valid_in;
    pqd_pkg::side_t             side_in;
    logic [63:0]                trial;
    logic                       take;

    if (j == 0) begin : g_first
      assign rem_in   = radicand_i;
      assign root_in  = '0;
      assign valid_in = valid_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign rem_in   = rem_q[j-1];
      assign root_in  = root_q[j-1];
      assign valid_in = valid_q[j-1];
      assign side_in  = side_q[j-1];
    end

    // Trial value (root + 2^bit)^2 - root^2
    assign trial = ({{(64-pqd_pkg::ROOT_W){1'b0}}, root_in} << (Bit + 1))
                 + (64'd1 << (2 * Bit));
    assign take  = {{(64-pqd_pkg::RAD_W){1'b0}}, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= valid_in;
      end
    end

    // Accept the bit where the remainder covers the trial
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= take ? (rem_in - trial[pqd_pkg::RAD_W-1:0]) : rem_in;
        root_q[j] <= take ? (root_in | (pqd_pkg::ROOT_W'(1) << Bit)) : root_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[NStage-1];
  assign root_o  = root_q[NStage-1];
  assign side_o  = side_q[NStage-1];

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps

// One decoded rotation: the word and the four output components expected for it
typedef struct packed {
  logic [pqd_pkg::WORD_W-1:0] word;
  logic [pqd_pkg::OUT_W-1:0]  x;
  logic [pqd_pkg::OUT_W-1:0]  y;
  logic [pqd_pkg::OUT_W-1:0]  z;
  logic [pqd_pkg::OUT_W-1:0]  w;
} quat_t;

// Round a Q30 magnitude to the output format, half away from zero, then
// saturate and apply the sign
function automatic logic [pqd_pkg::OUT_W-1:0] round_component(input logic [63:0] mag,
                                                              input logic neg);
  int unsigned shift;
  logic [63:0] q;
  shift = pqd_pkg::INT_FRAC_BITS - pqd_pkg::OUT_FRAC_BITS;
  q = mag;
  if (shift > 0) begin
    q = (q + (64'd1 << (shift - 1))) >> shift;
  end
  if (!neg && q > 64'd32767) begin
    q = 64'd32767;
  end
  if (neg && q > 64'd32768) begin
    q = 64'd32768;
  end
  if (neg) begin
    q = 64'd0 - q;
  end
  return q[pqd_pkg::OUT_W-1:0];
endfunction

// Floor square root of a 64-bit radicand, one result bit per pass
function automatic logic [63:0] floor_sqrt(input logic [63:0] radicand);
  logic [63:0] rest;
  logic [63:0] root;
  logic [63:0] probe;
  rest  = radicand;
  root  = 64'd0;
  probe = 64'd1 << 62;
  while (probe > rest) begin
    probe = probe >> 2;
  end
  while (probe != 64'd0) begin
    if (rest >= root + probe) begin
      rest = rest - (root + probe);
      root = (root >> 1) + probe;
    end else begin
      root = root >> 1;
    end
    probe = probe >> 2;
  end
  return root;
endfunction

// Unpack the three stored components, rebuild the fourth and place it
function automatic quat_t decode_rotation(input logic [pqd_pkg::WORD_W-1:0] word);
  logic [63:0] mag [3];
  logic        neg [3];
  logic [63:0] sq_sum;
  logic [63:0] unity;
  logic [63:0] remain;
  logic [63:0] root;
  logic [63:0] amag;
  logic [pqd_pkg::OUT_W-1:0] comp [4];
  logic [1:0]  slot;
  logic        flip;
  int          f;
  int          src;
  quat_t       res;
  sq_sum = 64'd0;
  unity  = 64'd1 << (2 * pqd_pkg::INT_FRAC_BITS);
  slot   = word[pqd_pkg::SLOT_LSB +: 2];
  flip   = word[pqd_pkg::NEGATE_BIT];
  // Recentre and scale each stored component to a Q30 magnitude
  for (int k = 0; k < pqd_pkg::NUM_FIELDS; k++) begin
    f = int'(word[pqd_pkg::FIELD_W*k +: pqd_pkg::FIELD_W]) - int'(pqd_pkg::FIELD_OFFSET);
    amag = (f < 0) ? 64'(-f) : 64'(f);
    mag[k] = (amag * 64'(pqd_pkg::SCALE_Q32) + 64'd2) >> 2;
    neg[k] = (f < 0);
    sq_sum = sq_sum + mag[k] * mag[k];
  end
  // Clamp a negative remainder to zero before the root
  remain = (sq_sum >= unity) ? 64'd0 : unity - sq_sum;
  root   = floor_sqrt(remain);
  src    = 0;
  for (int k = 0; k < 4; k++) begin
    if (k == int'(slot)) begin
      comp[k] = round_component(root, flip && root != 64'd0);
    end else begin
      comp[k] = round_component(mag[src], neg[src] && mag[src] != 64'd0);
      src++;
    end
  end
  res.word = word;
  res.x = comp[0];
  res.y = comp[1];
  res.z = comp[2];
  res.w = comp[3];
  return res;
endfunction

// Queue of decoded rotations awaiting their output transaction
class quat_tracker;
  quat_t pending[$];
  int    errors;

  function new();
    errors = 0;
  endfunction

  function void note_word(input logic [pqd_pkg::WORD_W-1:0] word);
    pending.push_back(decode_rotation(word));
  endfunction

  task report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_field(input string name, input logic [pqd_pkg::OUT_W-1:0] got,
                   input logic [pqd_pkg::OUT_W-1:0] want,
                   input logic [pqd_pkg::WORD_W-1:0] word);
    if (got !== want) begin
      report($sformatf("%s got %0d want %0d for word %010h", name, $signed(got),
                       $signed(want), word));
    end
  endtask

  task check_quat(input logic [pqd_pkg::OUT_W-1:0] x, input logic [pqd_pkg::OUT_W-1:0] y,
                  input logic [pqd_pkg::OUT_W-1:0] z, input logic [pqd_pkg::OUT_W-1:0] w);
    quat_t want;
    if (pending.size() == 0) begin
      report("output transaction with no word outstanding");
    end else begin
      want = pending.pop_front();
      check_field("comp_x", x, want.x, want.word);
      check_field("comp_y", y, want.y, want.word);
      check_field("comp_z", z, want.z, want.word);
      check_field("comp_w", w, want.w, want.word);
    end
  endtask
endclass

module tb_top;

  localparam logic [pqd_pkg::FIELD_W-1:0] CENTRE = pqd_pkg::FIELD_OFFSET;
  localparam int RANDOM_WORDS = 1450;
  localparam int LATENCY      = 38;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [pqd_pkg::WORD_W-1:0] packed_word_i = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic signed [pqd_pkg::OUT_W-1:0] comp_x_o;
  logic signed [pqd_pkg::OUT_W-1:0] comp_y_o;
  logic signed [pqd_pkg::OUT_W-1:0] comp_z_o;
  logic signed [pqd_pkg::OUT_W-1:0] comp_w_o;

  // Idle bursts off for the closing stretch; request for a long output hold
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  quat_tracker board = new();

  packed_quaternion_40bit_decode DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .packed_word_i (packed_word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .comp_x_o      (comp_x_o),
    .comp_y_o      (comp_y_o),
    .comp_z_o      (comp_z_o),
    .comp_w_o      (comp_w_o)
  );

  always #5 clk_i = ~clk_i;

  // Abandon the run if it hangs
  initial begin
    #2_000_000;
    $display("packed_quaternion_40bit_decode: mismatch");
    $finish;
  end

  // Check every output transaction against the oldest outstanding rotation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_quat(comp_x_o, comp_y_o, comp_z_o, comp_w_o);
    end
  end

  // Stall the output in short random bursts, or hold it off for a long stretch
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (150) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [pqd_pkg::WORD_W-1:0] pack_word(
      input logic spare, input logic flip, input logic [1:0] slot,
      input logic [11:0] f2, input logic [11:0] f1, input logic [11:0] f0);
    return {spare, flip, slot, f2, f1, f0};
  endfunction

  // Offer one word, hold it until accepted, then maybe idle for a burst
  task automatic send_word(input logic [pqd_pkg::WORD_W-1:0] word);
    in_valid_i <= 1'b1;
    packed_word_i <= word;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_word(word);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every outstanding rotation to come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
  endtask

  initial begin
    logic [63:0] r;
    logic [pqd_pkg::WORD_W-1:0] word;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes: all fields lowest and highest, both giving a negative remainder
    send_word('0);
    send_word({pqd_pkg::WORD_W{1'b1}});
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_X, 12'h000, 12'h000, 12'h000));
    // Zero vector part: rebuilt component has magnitude exactly one, in every slot
    send_word(pack_word(1'b0, 1'b0, pqd_pkg::SLOT_X, CENTRE, CENTRE, CENTRE));
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_Y, CENTRE, CENTRE, CENTRE));
    send_word(pack_word(1'b0, 1'b0, pqd_pkg::SLOT_Z, CENTRE, CENTRE, CENTRE));
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_W, CENTRE, CENTRE, CENTRE));
    // Unused top bit set
    send_word(pack_word(1'b1, 1'b0, pqd_pkg::SLOT_W, CENTRE, CENTRE, CENTRE));
    send_word(pack_word(1'b1, 1'b1, pqd_pkg::SLOT_X, 12'h123, 12'h9AB, 12'h456));
    // One step either side of the centre
    send_word(pack_word(1'b0, 1'b0, pqd_pkg::SLOT_W, 12'd2048, 12'd2050, 12'd2048));
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_Y, 12'd2050, 12'd2048, 12'd2050));
    // Single component at either end, the others centred
    send_word(pack_word(1'b0, 1'b0, pqd_pkg::SLOT_X, CENTRE, CENTRE, 12'h000));
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_Y, CENTRE, 12'hFFF, CENTRE));
    send_word(pack_word(1'b0, 1'b0, pqd_pkg::SLOT_Z, 12'h000, CENTRE, CENTRE));
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_W, 12'hFFF, CENTRE, CENTRE));
    // Mixed components in each slot with a positive remainder
    send_word(pack_word(1'b0, 1'b0, pqd_pkg::SLOT_X, 12'd1200, 12'd2900, 12'd1500));
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_Y, 12'd2800, 12'd1300, 12'd2700));
    send_word(pack_word(1'b0, 1'b0, pqd_pkg::SLOT_Z, 12'd400, 12'd3700, 12'd2049));
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_W, 12'd3000, 12'd1100, 12'd1000));
    // Small positive remainder, then a negative one with the rebuilt component clamped to zero
    send_word(pack_word(1'b0, 1'b1, pqd_pkg::SLOT_Z, 12'd400, 12'd3700, 12'd3700));
    send_word(pack_word(1'b0, 1'b0, pqd_pkg::SLOT_W, 12'h000, 12'hFFF, 12'h000));

    // Random words: most with every field in 399 to 3699, keeping the remainder positive, the rest any 40-bit value
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) begin
        hold_req = 1'b1;
      end
      if (n == 700) begin
        drain();
      end
      if (n == RANDOM_WORDS - 200) begin
        quiet = 1'b1;
      end
      r = {$urandom, $urandom};
      if ($urandom_range(0, 9) < 6) begin
        word = pack_word(r[39], r[38], r[37:36], 12'($urandom_range(399, 3699)),
                         12'($urandom_range(399, 3699)), 12'($urandom_range(399, 3699)));
      end else begin
        word = r[pqd_pkg::WORD_W-1:0];
      end
      send_word(word);
    end

    // Let the pipeline empty, then a margin for any stray transaction
    drain();
    repeat (LATENCY + 12) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("packed_quaternion_40bit_decode: match");
    end else begin
      $display("packed_quaternion_40bit_decode: mismatch");
    end
    $finish;
  end

endmodule
